[rtl/section_table_address_translator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Section table address translator: assertion macros
// Macros for the concurrent checks of the translator sequencer.
// ----------------------------------------------------------------------------
`ifndef SECTION_TABLE_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`define SECTION_TABLE_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STAT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STAT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/stat_pkg.sv]
// ----------------------------------------------------------------------------
// Section table address translator package
// Types, codes and sizing constants shared by the translator modules.
// ----------------------------------------------------------------------------
package stat_pkg;

	localparam int unsigned MAX_SECTIONS = 32;
	localparam int unsigned CNT_W = $clog2(MAX_SECTIONS + 1);
	localparam int unsigned IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
	localparam int unsigned HELD_W = 6;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SECTIONS);

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_XLATE = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MISALIGNED = 3'd1;
	localparam logic [2:0] ST_PAST_IMAGE = 3'd2;
	localparam logic [2:0] ST_OUTSIDE_FILE = 3'd3;
	localparam logic [2:0] ST_OVERLAP = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_NOT_FOUND = 3'd6;

	localparam logic [2:0] REG_FILE_LENGTH = 3'd0;
	localparam logic [2:0] REG_HEADER_BYTES = 3'd1;
	localparam logic [2:0] REG_IMAGE_BYTES = 3'd2;
	localparam logic [2:0] REG_SECTION_ALIGN = 3'd3;
	localparam logic [2:0] REG_LOAD_BASE = 3'd4;
	localparam logic [2:0] REG_ENTRY_ADDRESS = 3'd5;

	localparam logic [31:0] ALIGN_RESET = 32'd4096;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] rel_addr;
		logic [31:0] virt_len;
		logic [31:0] raw_len;
		logic [31:0] raw_start;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] file_offset;
		logic image_ok;
		logic [HELD_W-1:0] sections_held;
	} result_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] vlen;
		logic [31:0] rlen;
		logic [31:0] rstart;
	} sect_t;

	localparam int unsigned SECT_W = $bits(sect_t);

	typedef struct packed {
		logic [31:0] file_length;
		logic [31:0] header_bytes;
		logic [31:0] image_bytes;
		logic [31:0] section_align;
		logic glb_ok;
	} cfg_view_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		sect_t wdata;
		logic re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

[rtl/section_table_address_translator_unit.sv]
// A clear, an unused op, a translate below the header size, an empty table, a load into a
// full table or a load failing its own checks skips the scan; any other load or translate
// scans the held sections in order up to the first hit. The scan reads one stored section
// per cycle from the section memory's read port. A new start is taken the cycle after the
// result strobe. Reset clears the section count and the sticky error at once and sets the
// configuration registers to their defaults; the section memory itself is not cleared.
// ----------------------------------------------------------------------------
// Section table address translator
// Holds a section table and maps relative addresses to file offsets.
// ----------------------------------------------------------------------------
module section_table_address_translator_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	input stat_pkg::item_t item,
	output logic busy,
	output logic done,
	output stat_pkg::result_t result,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	import stat_pkg::*;

	cfg_view_t cfg;
	ram_req_t ram_req;
	logic [SECT_W-1:0] rd_bits;
	sect_t rd_data;

	assign rd_data = sect_t'(rd_bits);

	stat_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	stat_ram #(
		.WIDTH(SECT_W),
		.DEPTH(MAX_SECTIONS)
	) u_store (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re(ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(rd_bits)
	);

	stat_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.cfg(cfg),
		.rd_data(rd_data),
		.ram_req(ram_req),
		.busy(busy),
		.done(done),
		.result(result)
	);

endmodule

[rtl/stat_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle, no reset on the contents.
// ----------------------------------------------------------------------------
module stat_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/stat_cfg.sv]
// ----------------------------------------------------------------------------
// Translator configuration registers
// Holds the image registers and derives the global image validity flag.
// ----------------------------------------------------------------------------
module stat_cfg (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data,
	output stat_pkg::cfg_view_t cfg
);
	import stat_pkg::*;

	logic [31:0] file_length_q;
	logic [31:0] header_bytes_q;
	logic [31:0] image_bytes_q;
	logic [31:0] section_align_q;
	logic [63:0] load_base_q;
	logic [63:0] entry_address_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			header_bytes_q <= '0;
			image_bytes_q <= '0;
			section_align_q <= ALIGN_RESET;
			load_base_q <= '0;
			entry_address_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILE_LENGTH: file_length_q <= cfg_data[31:0];
				REG_HEADER_BYTES: header_bytes_q <= cfg_data[31:0];
				REG_IMAGE_BYTES: image_bytes_q <= cfg_data[31:0];
				REG_SECTION_ALIGN: section_align_q <= cfg_data[31:0];
				REG_LOAD_BASE: load_base_q <= cfg_data;
				REG_ENTRY_ADDRESS: entry_address_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.file_length = file_length_q;
		cfg.header_bytes = header_bytes_q;
		cfg.image_bytes = image_bytes_q;
		cfg.section_align = section_align_q;
		cfg.glb_ok = (image_bytes_q != '0) && (header_bytes_q != '0)
			&& (entry_address_q >= load_base_q)
			&& (header_bytes_q <= image_bytes_q)
			&& (header_bytes_q <= file_length_q);
	end

endmodule

[rtl/stat_seq.sv]
// ----------------------------------------------------------------------------
// Translator sequencer
// Checks loads, scans the section memory and forms one result per item.
// ----------------------------------------------------------------------------
module stat_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input stat_pkg::item_t item,
	input stat_pkg::cfg_view_t cfg,
	input stat_pkg::sect_t rd_data,
	output stat_pkg::ram_req_t ram_req,
	output logic busy,
	output logic done,
	output stat_pkg::result_t result
);
	import stat_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_UPDATE = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic sticky_q;
	logic [CNT_W-1:0] idx_q;
	logic rd_vld_s1;

	logic [1:0] op_q;
	sect_t cur_q;
	logic [31:0] end_q;
	logic [2:0] pre_q;
	logic low_q;
	logic hit_q;
	sect_t hit_entry_q;
	logic [2:0] status_q;
	logic [31:0] offset_q;

	logic accept;
	logic [31:0] align_mask;
	logic [31:0] in_end;
	logic [2:0] pre_status;
	logic in_low;
	logic need_scan;
	logic [31:0] oend;
	logic ovl_hit;
	logic xl_hit;
	logic hit_now;
	logic rd_en;
	logic scan_end;
	logic full;
	logic [2:0] load_status;

	assign accept = start && (state_q == S_IDLE);
	assign busy = (state_q != S_IDLE);
	assign full = (count_q >= MAX_CNT);

	always_comb begin
		align_mask = cfg.section_align - 32'd1;
		in_end = item.rel_addr + item.virt_len;
		in_low = (item.rel_addr < cfg.header_bytes);
		if ((item.rel_addr & align_mask) != '0) begin
			pre_status = ST_MISALIGNED;
		end else if (in_end > cfg.image_bytes) begin
			pre_status = ST_PAST_IMAGE;
		end else if ((item.raw_len != '0) && ((item.raw_start >= cfg.file_length)
				|| (item.raw_len > (cfg.file_length - item.raw_start)))) begin
			pre_status = ST_OUTSIDE_FILE;
		end else begin
			pre_status = ST_OK;
		end
		case (item.op)
			OP_LOAD: need_scan = !full && (pre_status == ST_OK) && (count_q != '0);
			OP_XLATE: need_scan = !in_low && (count_q != '0);
			default: need_scan = 1'b0;
		endcase
	end

	always_comb begin
		oend = rd_data.start + rd_data.vlen;
		ovl_hit = (cur_q.start < oend) && (rd_data.start < end_q);
		xl_hit = (rd_data.rlen != '0) && (cur_q.start >= rd_data.start)
			&& (cur_q.start < oend);
		hit_now = rd_vld_s1 && ((op_q == OP_LOAD) ? ovl_hit : xl_hit);
		rd_en = (state_q == S_SCAN) && (idx_q < count_q);
		scan_end = hit_now || (idx_q >= count_q);
		if (pre_q != ST_OK) begin
			load_status = pre_q;
		end else if (hit_q) begin
			load_status = ST_OVERLAP;
		end else begin
			load_status = ST_OK;
		end
	end

	always_comb begin
		ram_req.re = rd_en;
		ram_req.raddr = idx_q[IDX_W-1:0];
		ram_req.we = (state_q == S_UPDATE) && (op_q == OP_LOAD) && !full;
		ram_req.waddr = count_q[IDX_W-1:0];
		ram_req.wdata = cur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sticky_q <= 1'b0;
			idx_q <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						rd_vld_s1 <= 1'b0;
						hit_q <= 1'b0;
						state_q <= need_scan ? S_SCAN : S_UPDATE;
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						hit_q <= hit_now;
						rd_vld_s1 <= 1'b0;
						state_q <= S_UPDATE;
					end else begin
						rd_vld_s1 <= rd_en;
						if (rd_en) begin
							idx_q <= idx_q + CNT_W'(1);
						end
					end
				end
				S_UPDATE: begin
					case (op_q)
						OP_CLEAR: begin
							count_q <= '0;
							sticky_q <= 1'b0;
						end
						OP_LOAD: begin
							if (full) begin
								sticky_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
								if (load_status != ST_OK) begin
									sticky_q <= 1'b1;
								end
							end
						end
						default: ;
					endcase
					state_q <= S_RESP;
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.op;
			cur_q.start <= item.rel_addr;
			cur_q.vlen <= item.virt_len;
			cur_q.rlen <= item.raw_len;
			cur_q.rstart <= item.raw_start;
			end_q <= in_end;
			pre_q <= pre_status;
			low_q <= in_low;
		end
		if ((state_q == S_SCAN) && scan_end) begin
			hit_entry_q <= rd_data;
		end
		if (state_q == S_UPDATE) begin
			case (op_q)
				OP_LOAD: begin
					status_q <= full ? ST_FULL : load_status;
					offset_q <= '0;
				end
				OP_XLATE: begin
					if (low_q) begin
						status_q <= ST_OK;
						offset_q <= cur_q.start;
					end else if (hit_q) begin
						status_q <= ST_OK;
						offset_q <= hit_entry_q.rstart + (cur_q.start - hit_entry_q.start);
					end else begin
						status_q <= ST_NOT_FOUND;
						offset_q <= '0;
					end
				end
				default: begin
					status_q <= ST_OK;
					offset_q <= '0;
				end
			endcase
		end
	end

	assign done = (state_q == S_RESP);

	always_comb begin
		result.status = status_q;
		result.file_offset = offset_q;
		result.image_ok = cfg.glb_ok && (count_q != '0) && !sticky_q;
		result.sections_held = HELD_W'(count_q);
	end

`include "section_table_address_translator_unit_assert.svh"

	`STAT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= MAX_CNT, "section count exceeds table size")
	`STAT_ASSERT_NOW(a_write_room, ram_req.we, count_q < MAX_CNT, "section write into full table")
	`STAT_ASSERT_NOW(a_read_scan, rd_vld_s1, state_q == S_SCAN, "read data pending outside a scan")
	`STAT_ASSERT_NOW(a_sticky_clear, $fell(sticky_q), $past(op_q) == OP_CLEAR, "sticky error dropped without clear")
	`STAT_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item did not raise busy")

endmodule

[sim/tb_section_table_address_translator_unit.sv]
// ----------------------------------------------------------------------------
// Section table address translator testbench
// Drives clear, load, translate and unused-op commands through the start/busy port, with
// bursts and gaps on the sender side. Registers are rewritten between phases,
// including extreme settings. A scoreboard keeps its own copy of the section
// table and registers, predicts every response and checks each done strobe
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_section_table_address_translator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import stat_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int unsigned RANDOM_ITEMS = 1250;
	localparam int unsigned SETTLE_CYCLES = 2 * MAX_SECTIONS + 8;

	class section_table_scoreboard;
		logic [31:0] file_length;
		logic [31:0] header_bytes;
		logic [31:0] image_bytes;
		logic [31:0] section_align;
		logic [63:0] load_base;
		logic [63:0] entry_address;
		sect_t sections[MAX_SECTIONS];
		int unsigned held;
		bit sticky;
		result_t awaited[$];
		int unsigned mismatches;

		function new();
			file_length = '0;
			header_bytes = '0;
			image_bytes = '0;
			section_align = ALIGN_RESET;
			load_base = '0;
			entry_address = '0;
			held = 0;
			sticky = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(logic [2:0] index, logic [63:0] value);
			case (index)
				REG_FILE_LENGTH: file_length = value[31:0];
				REG_HEADER_BYTES: header_bytes = value[31:0];
				REG_IMAGE_BYTES: image_bytes = value[31:0];
				REG_SECTION_ALIGN: section_align = value[31:0];
				REG_LOAD_BASE: load_base = value;
				REG_ENTRY_ADDRESS: entry_address = value;
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction

		// Applies one accepted command to the table and queues its response.
		function void note_command(item_t cmd);
			result_t r;
			sect_t s;
			sect_t o;
			logic [31:0] s_end;
			logic [31:0] o_end;
			logic [31:0] room;
			bit found;
			int i;

			r = '0;
			r.status = ST_OK;
			case (cmd.op)
				OP_CLEAR: begin
					held = 0;
					sticky = 1'b0;
				end
				OP_LOAD: begin
					if (held >= MAX_SECTIONS) begin
						r.status = ST_FULL;
						sticky = 1'b1;
					end else begin
						s.start = cmd.rel_addr;
						s.vlen = cmd.virt_len;
						s.rlen = cmd.raw_len;
						s.rstart = cmd.raw_start;
						s_end = s.start + s.vlen;
						room = file_length - s.rstart;
						if ((s.start & (section_align - 32'd1)) != 32'd0) begin
							r.status = ST_MISALIGNED;
						end else if (s_end > image_bytes) begin
							r.status = ST_PAST_IMAGE;
						end else if (s.rlen != 32'd0 &&
								(s.rstart >= file_length || s.rlen > room)) begin
							r.status = ST_OUTSIDE_FILE;
						end else begin
							for (i = 0; i < held; i++) begin
								o = sections[i];
								o_end = o.start + o.vlen;
								if (s.start < o_end && o.start < s_end)
									r.status = ST_OVERLAP;
							end
						end
						if (r.status != ST_OK)
							sticky = 1'b1;
						sections[held] = s;
						held++;
					end
				end
				OP_XLATE: begin
					if (cmd.rel_addr < header_bytes) begin
						r.file_offset = cmd.rel_addr;
					end else begin
						found = 1'b0;
						for (i = 0; i < held; i++) begin
							o = sections[i];
							o_end = o.start + o.vlen;
							if (!found && o.rlen != 32'd0 && cmd.rel_addr >= o.start &&
									cmd.rel_addr < o_end) begin
								r.file_offset = o.rstart + (cmd.rel_addr - o.start);
								found = 1'b1;
							end
						end
						if (!found)
							r.status = ST_NOT_FOUND;
					end
				end
				default: ;
			endcase
			r.image_ok = image_bytes != 32'd0 && header_bytes != 32'd0 &&
				entry_address >= load_base && header_bytes <= image_bytes &&
				header_bytes <= file_length && held != 0 && !sticky;
			r.sections_held = HELD_W'(held);
			awaited.push_back(r);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 50)
				$display("[%0t] mismatch: %s", $realtime, what);
		endtask

		task check_response(result_t got);
			result_t want;

			if (awaited.size() == 0) begin
				report_mismatch($sformatf("response with none outstanding, status %0d offset %h",
					got.status, got.file_offset));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
			if (got.file_offset !== want.file_offset)
				report_mismatch($sformatf("file_offset %h, predicted %h",
					got.file_offset, want.file_offset));
			if (got.image_ok !== want.image_ok)
				report_mismatch($sformatf("image_ok %b, predicted %b", got.image_ok, want.image_ok));
			if (got.sections_held !== want.sections_held)
				report_mismatch($sformatf("sections_held %0d, predicted %0d",
					got.sections_held, want.sections_held));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	section_table_scoreboard board;
	int unsigned burst_left;
	int unsigned sent;

	section_table_address_translator_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_response(result);
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 255);
			3: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	function automatic item_t make_cmd(logic [1:0] op, logic [31:0] addr, logic [31:0] vlen,
			logic [31:0] rlen, logic [31:0] rstart);
		item_t cmd;

		cmd.op = op;
		cmd.rel_addr = addr;
		cmd.virt_len = vlen;
		cmd.raw_len = rlen;
		cmd.raw_start = rstart;
		return cmd;
	endfunction

	// The sender works in bursts; a gap of idle cycles may open before each burst.
	task automatic send_command(input item_t cmd);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		item <= cmd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_command(cmd);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] index, input logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		board.set_register(index, value);
		@(posedge clk);
	endtask

	task automatic configure_image();
		logic [31:0] align_v;
		logic [31:0] img;
		logic [63:0] base;

		align_v = 32'd1 << $urandom_range(9, 16);
		img = $urandom_range(32'h0100_0000, 32'h4000_0000);
		base = {$urandom(), $urandom()} & ~64'hFFFF;
		write_register(REG_FILE_LENGTH, {$urandom(),
			32'($urandom_range(32'h0100_0000, 32'hFFFF_FFFF))});
		write_register(REG_HEADER_BYTES, {$urandom(), 32'($urandom_range(1, align_v))});
		write_register(REG_IMAGE_BYTES, {$urandom(), img});
		write_register(REG_SECTION_ALIGN, {$urandom(), align_v});
		write_register(REG_LOAD_BASE, base);
		write_register(REG_ENTRY_ADDRESS, ($urandom_range(0, 9) == 0) ? base - 64'd1 :
			base + 64'($urandom_range(0, img)));
		cfg_we <= 1'b0;
	endtask

	task automatic configure_extreme();
		logic [31:0] align_v;

		case ($urandom_range(0, 7))
			0: align_v = 32'd0;
			1: align_v = 32'd1;
			2: align_v = 32'd3;
			3: align_v = 32'd512;
			4: align_v = 32'h8000_0000;
			5: align_v = 32'hFFFF_FFFF;
			6: align_v = 32'd1 << $urandom_range(9, 31);
			default: align_v = $urandom();
		endcase
		write_register(REG_SPARE_A, {rand_word(), rand_word()});
		write_register(REG_FILE_LENGTH, {rand_word(), rand_word()});
		write_register(REG_HEADER_BYTES, {rand_word(), rand_word()});
		write_register(REG_IMAGE_BYTES, {rand_word(), rand_word()});
		write_register(REG_SECTION_ALIGN, {rand_word(), align_v});
		write_register(REG_LOAD_BASE, {rand_word(), rand_word()});
		write_register(REG_ENTRY_ADDRESS, {rand_word(), rand_word()});
		write_register(REG_SPARE_B, {rand_word(), rand_word()});
		cfg_we <= 1'b0;
	endtask

	// Clear, a run of mostly legal loads laid out in order, then translates aimed mostly
	// at what was loaded. A few loads are broken on purpose.
	task automatic run_image_sequence(input bit fill);
		sect_t placed[$];
		sect_t s;
		logic [31:0] mask;
		logic [31:0] span;
		logic [31:0] cursor;
		logic [31:0] raw_cursor;
		logic [31:0] cursor_next;
		logic [31:0] raw_next;
		logic [31:0] addr;
		int unsigned loads;

		mask = board.section_align - 32'd1;
		span = (board.section_align > 32'h0001_0000 || board.section_align == 32'd0) ?
			32'h0001_0000 : board.section_align;
		cursor = (board.header_bytes + mask) & ~mask;
		raw_cursor = board.header_bytes;
		send_command(make_cmd(OP_CLEAR, $urandom(), $urandom(), $urandom(), $urandom()));
		if (fill)
			loads = MAX_SECTIONS + 1;
		else
			loads = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 10);
		repeat (loads) begin
			s.start = cursor;
			s.vlen = $urandom_range(1, 4 * span);
			s.rlen = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, s.vlen));
			s.rstart = raw_cursor;
			cursor_next = (cursor + s.vlen + mask + ($urandom_range(0, 1) ? span : 32'd0)) & ~mask;
			raw_next = raw_cursor + ((s.rlen + 32'd511) & ~32'd511);
			case ($urandom_range(0, 19))
				0: s.start = s.start | ($urandom() & mask);
				1: s.vlen = board.image_bytes - s.start + $urandom_range(1, span);
				2: begin
					s.rstart = board.file_length - $urandom_range(0, 255);
					s.rlen = $urandom_range(257, 4096);
				end
				3: begin
					if (placed.size() != 0)
						s.start = placed[$urandom_range(0, placed.size() - 1)].start;
				end
				default: ;
			endcase
			send_command(make_cmd(OP_LOAD, s.start, s.vlen, s.rlen, s.rstart));
			placed.push_back(s);
			cursor = cursor_next;
			raw_cursor = raw_next;
		end
		repeat ($urandom_range(2, 16)) begin
			s = placed[$urandom_range(0, placed.size() - 1)];
			case ($urandom_range(0, 5))
				0, 1, 2: addr = (s.vlen != 32'd0) ? s.start + ($urandom() % s.vlen) : s.start;
				3: addr = $urandom_range(0, board.header_bytes);
				4: addr = s.start + s.vlen;
				default: addr = rand_word();
			endcase
			send_command(make_cmd(OP_XLATE, addr, $urandom(), $urandom(), $urandom()));
		end
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 8))
			send_command(make_cmd(2'($urandom_range(0, 3)), rand_word(), rand_word(),
				rand_word(), rand_word()));
	endtask

	initial begin
		int unsigned target;
		int unsigned phase;

		board = new();
		burst_left = 0;
		sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register defaults straight out of reset.
		send_command(make_cmd(OP_XLATE, 32'd0, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_command(make_cmd(OP_LOAD, 32'd0, 32'd0, 32'd0, 32'd0));
		drain();
		write_register(REG_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF);
		write_register(REG_FILE_LENGTH, 64'hFFFF_FFFF_0001_0000);
		write_register(REG_HEADER_BYTES, 64'h0000_0000_0000_0400);
		write_register(REG_IMAGE_BYTES, 64'h0000_0000_0002_0000);
		write_register(REG_SECTION_ALIGN, 64'h0000_0000_0000_1000);
		write_register(REG_LOAD_BASE, 64'hFFFF_FFFF_0000_0000);
		write_register(REG_ENTRY_ADDRESS, 64'hFFFF_FFFF_0000_1000);
		write_register(REG_SPARE_B, 64'hFFFF_FFFF_FFFF_FFFF);
		cfg_we <= 1'b0;

		send_command(make_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'h1000, 32'h2000, 32'h1800, 32'h400));
		send_command(make_cmd(OP_XLATE, 32'h1800, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'h3010, 32'h100, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'h1F000, 32'h2000, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'h4000, 32'h1000, 32'd1, 32'h10000));
		send_command(make_cmd(OP_LOAD, 32'h5000, 32'h1000, 32'h1001, 32'hF000));
		send_command(make_cmd(OP_LOAD, 32'h2000, 32'h1000, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'hFFFF_F000, 32'h2000, 32'h100, 32'h8000));
		send_command(make_cmd(OP_XLATE, 32'h3FF, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_XLATE, 32'h400, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_XLATE, 32'h2FFF, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_XLATE, 32'h3000, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_XLATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_command(make_cmd(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_command(make_cmd(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		send_command(make_cmd(OP_CLEAR, 32'd0, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_LOAD, 32'h1000, 32'd0, 32'h200, 32'hFE00));
		send_command(make_cmd(OP_XLATE, 32'h1000, 32'd0, 32'd0, 32'd0));
		send_command(make_cmd(OP_SPARE, 32'd0, 32'd0, 32'd0, 32'd0));

		target = sent + RANDOM_ITEMS;
		phase = 0;
		while (sent < target) begin
			drain();
			if (phase % 4 == 3)
				configure_extreme();
			else
				configure_image();
			if (phase == 0)
				run_image_sequence(1'b1);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 4) == 0)
					run_noise();
				else
					run_image_sequence(1'b0);
			end
			if (phase % 3 == 1) begin
				drain();
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			phase++;
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/stat_pkg.sv
rtl/stat_ram.sv
rtl/stat_cfg.sv
rtl/stat_seq.sv
rtl/section_table_address_translator_unit.sv
sim/tb_section_table_address_translator_unit.sv
